@@ rtl/sedh_pkg.sv @@
package sedh_pkg;

    localparam int MAX_WIDTH = 512;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int COL_W     = ADDR_W + 1;
    localparam int ERR_W     = 12;
    localparam int TAG_W     = 4;
    localparam int NCH       = 3;
    localparam int PIX_W     = 8;
    localparam int SUM_W     = ERR_W + 2;
    localparam int PROD_W    = SUM_W + 4;
    localparam int CFG_W     = 10;
    localparam int RES_W     = NCH + 1;
    localparam int FIFO_DEPTH = 3;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam int FS_ALONG  = 7;
    localparam int FS_BELOW  = 5;
    localparam int FS_BEHIND = 3;
    localparam int FS_DIV    = 16;

    typedef logic signed [ERR_W-1:0] err_t;
    typedef logic [TAG_W-1:0]        tag_t;
    typedef logic [ADDR_W-1:0]       addr_t;
    typedef logic [COL_W-1:0]        col_t;
    typedef logic [PIX_W-1:0]        pix_t;

    typedef struct packed {
        tag_t                tag;
        err_t [NCH-1:0]      err;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic {
        REG_IMAGE_WIDTH = 1'b0,
        REG_THRESHOLD   = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_RUN,
        ST_DRAIN
    } state_t;

    localparam col_t  WIDTH_RESET  = col_t'(500);
    localparam pix_t  THRESH_RESET = pix_t'(127);
    localparam pix_t  FULL_LEVEL   = pix_t'(255);
    localparam tag_t  TAG_LAST     = '1;
    localparam err_t  ERR_MAX      = err_t'({1'b0, {(ERR_W-1){1'b1}}});
    localparam err_t  ERR_MIN      = err_t'({1'b1, {(ERR_W-1){1'b0}}});

    function automatic err_t sat_err(input logic signed [PROD_W-1:0] x);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = PROD_W'(ERR_MAX);
        lo = PROD_W'(ERR_MIN);
        if (x > hi)
            return ERR_MAX;
        if (x < lo)
            return ERR_MIN;
        return err_t'(x);
    endfunction

endpackage

@@ rtl/serpentine_error_diffusion_halftone.sv @@
// Channel   Dir  Transfer rule          Payload
// s_axis    in   tvalid & tready        tdata: red, green, blue; tuser: start_of_frame
// m_axis    out  tvalid & tready        tdata: red_on, green_on, blue_on; tlast: end_of_row
// cfg       in   cfg_we at clock edge   cfg_addr: register index; cfg_wdata: value
//
// One pixel per cycle while s_axis_tready is high; each result passes the registered
// read of the line store and the error update stage behind it into the result queue.
// After reset all 512 line store entries are swept to zero with s_axis_tready low.
// Every sixteenth start of frame repeats that sweep, after a drain of the update stage,
// before the pixel is taken; other frame starts cost nothing.
// A three-entry result queue absorbs m_axis stalls; s_axis stalls when it would overfill.
module serpentine_error_diffusion_halftone (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  sedh_pkg::reg_idx_t           cfg_addr,
    input  logic [sedh_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [23:0]                  s_axis_tdata,  // red[7:0], green[15:8], blue[23:16]
    input  logic                         s_axis_tuser,  // start_of_frame
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [7:0]                   m_axis_tdata,  // red_on[0], green_on[1], blue_on[2]
    output logic                         m_axis_tlast   // end_of_row
);

    import sedh_pkg::*;

    // configuration
    col_t   width_reg;
    pix_t   thresh_reg;

    // control state
    state_t state_reg;
    state_t state_next;
    addr_t  clr_cnt_reg;
    addr_t  clr_cnt_next;
    logic   fresh_reg;
    tag_t   epoch_reg;
    col_t   colpos_reg;
    logic   rev_reg;

    // input stage
    logic   accept;
    logic   sof_in;
    logic   wrap_req;
    logic   room;
    col_t   width_eff;
    col_t   last_pos;
    col_t   pos_raw;
    col_t   pos;
    col_t   col0;
    col_t   behind0;
    logic   rev0;
    logic   last0;
    tag_t   epoch_cur;

    // update stage
    logic                s1_valid_reg;
    addr_t               s1_col_reg;
    addr_t               s1_behind_reg;
    logic                s1_last_reg;
    logic                s1_has_behind_reg;
    logic                s1_sof_reg;
    tag_t                s1_epoch_reg;
    pix_t [NCH-1:0]      s1_pix_reg;

    err_t [NCH-1:0]      along_reg;
    err_t [NCH-1:0]      win_behind_reg;
    err_t [NCH-1:0]      win_below_reg;

    entry_t              mem_entry;
    entry_t              fwd_entry;
    err_t [NCH-1:0]      stored;
    err_t [NCH-1:0]      along_in;
    err_t [NCH-1:0]      wb_in;
    err_t [NCH-1:0]      wd_in;
    logic [NCH-1:0]      quant_on;
    err_t [NCH-1:0]      along_nx;
    err_t [NCH-1:0]      w_behind;
    err_t [NCH-1:0]      w_below;
    err_t [NCH-1:0]      w_ahead;

    // deferred write of the turn column and last write seen by the port
    logic                pend_valid_reg;
    addr_t               pend_addr_reg;
    entry_t              pend_entry_reg;
    logic                lastwr_valid_reg;
    addr_t               lastwr_addr_reg;
    entry_t              lastwr_entry_reg;

    logic                ram_we;
    addr_t               ram_waddr;
    entry_t              ram_wentry;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic                s1_wr;

    // result queue
    logic [RES_W-1:0]    fifo_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] fifo_cnt_reg;
    logic                push;
    logic                pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            thresh_reg <= THRESH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_IMAGE_WIDTH: width_reg  <= cfg_wdata;
                REG_THRESHOLD:   thresh_reg <= cfg_wdata[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    // position in the row
    assign sof_in    = s_axis_tuser;
    assign width_eff = (width_reg == '0) ? col_t'(1) :
                       (width_reg > col_t'(MAX_WIDTH)) ? col_t'(MAX_WIDTH) : width_reg;
    assign last_pos  = width_eff - col_t'(1);
    assign pos_raw   = sof_in ? '0 : colpos_reg;
    assign rev0      = sof_in ? 1'b0 : rev_reg;
    assign pos       = (pos_raw > last_pos) ? last_pos : pos_raw;
    assign col0      = rev0 ? (last_pos - pos) : pos;
    assign behind0   = rev0 ? (col0 + col_t'(1)) : (col0 - col_t'(1));
    assign last0     = (pos == last_pos);
    assign epoch_cur = sof_in ? (epoch_reg + tag_t'(1)) : epoch_reg;

    assign wrap_req = s_axis_tvalid && sof_in && (epoch_reg == TAG_LAST) && !fresh_reg;
    assign room     = ({1'b0, fifo_cnt_reg} + (FIFO_CNT_W+1)'(s1_valid_reg))
                      < (FIFO_CNT_W+1)'(FIFO_DEPTH);
    assign s_axis_tready = (state_reg == ST_RUN) && room && !wrap_req;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = '0;
        case (state_reg)
            ST_RUN:
            begin
                if (wrap_req)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!s1_valid_reg && !pend_valid_reg)
                    state_next = ST_CLEAR;
            end
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + addr_t'(1);
                if (clr_cnt_reg == addr_t'(MAX_WIDTH - 1))
                    state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            fresh_reg   <= 1'b0;
            epoch_reg   <= '0;
            colpos_reg  <= '0;
            rev_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            if (state_reg == ST_CLEAR && state_next == ST_RUN)
                fresh_reg <= 1'b1;
            else if (accept && sof_in)
                fresh_reg <= 1'b0;
            if (accept)
            begin
                epoch_reg <= epoch_cur;
                if (last0)
                begin
                    colpos_reg <= '0;
                    rev_reg    <= !rev0;
                end
                else
                begin
                    colpos_reg <= pos + col_t'(1);
                    rev_reg    <= rev0;
                end
            end
        end
    end

    // hand the pixel to the update stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg        <= col0[ADDR_W-1:0];
            s1_behind_reg     <= behind0[ADDR_W-1:0];
            s1_last_reg       <= last0;
            s1_has_behind_reg <= (pos != '0);
            s1_sof_reg        <= sof_in;
            s1_epoch_reg      <= epoch_cur;
            s1_pix_reg[0]     <= s_axis_tdata[7:0];
            s1_pix_reg[1]     <= s_axis_tdata[15:8];
            s1_pix_reg[2]     <= s_axis_tdata[23:16];
        end
    end

    // forward writes the memory read could not see
    always_comb
    begin
        mem_entry = entry_t'(ram_rdata);
        if (pend_valid_reg && (pend_addr_reg == s1_col_reg))
            fwd_entry = pend_entry_reg;
        else if (lastwr_valid_reg && (lastwr_addr_reg == s1_col_reg))
            fwd_entry = lastwr_entry_reg;
        else
            fwd_entry = mem_entry;
    end

    for (genvar c = 0; c < NCH; c++)
    begin : g_chan
        assign stored[c]   = (fwd_entry.tag == s1_epoch_reg) ? fwd_entry.err[c] : '0;
        assign along_in[c] = s1_sof_reg ? '0 : along_reg[c];
        assign wb_in[c]    = s1_sof_reg ? '0 : win_behind_reg[c];
        assign wd_in[c]    = s1_sof_reg ? '0 : win_below_reg[c];

        sedh_chan u_chan (
            .pixel      (s1_pix_reg[c]),
            .stored     (stored[c]),
            .along      (along_in[c]),
            .win_behind (wb_in[c]),
            .win_below  (wd_in[c]),
            .threshold  (thresh_reg),
            .last       (s1_last_reg),
            .quant_on   (quant_on[c]),
            .along_next (along_nx[c]),
            .w_behind   (w_behind[c]),
            .w_below    (w_below[c]),
            .w_ahead    (w_ahead[c])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            along_reg      <= '0;
            win_behind_reg <= '0;
            win_below_reg  <= '0;
        end
        else if (s1_valid_reg)
        begin
            along_reg <= along_nx;
            if (s1_last_reg)
            begin
                win_behind_reg <= '0;
                win_below_reg  <= '0;
            end
            else
            begin
                win_behind_reg <= w_below;
                win_below_reg  <= w_ahead;
            end
        end
    end

    // line store write port: sweep, deferred turn column, or the column behind
    assign s1_wr = s1_valid_reg && s1_has_behind_reg;

    always_comb
    begin
        ram_we     = 1'b0;
        ram_waddr  = s1_behind_reg;
        ram_wentry = '{tag: s1_epoch_reg, err: w_behind};
        if (state_reg == ST_CLEAR)
        begin
            ram_we     = 1'b1;
            ram_waddr  = clr_cnt_reg;
            ram_wentry = '0;
        end
        else if (pend_valid_reg)
        begin
            ram_we     = 1'b1;
            ram_waddr  = pend_addr_reg;
            ram_wentry = pend_entry_reg;
        end
        else if (s1_wr)
        begin
            ram_we = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg   <= 1'b0;
            lastwr_valid_reg <= 1'b0;
        end
        else
        begin
            pend_valid_reg   <= s1_valid_reg && s1_last_reg;
            lastwr_valid_reg <= ram_we;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_last_reg)
        begin
            pend_addr_reg  <= s1_col_reg;
            pend_entry_reg <= '{tag: s1_epoch_reg, err: w_below};
        end
        lastwr_addr_reg  <= ram_waddr;
        lastwr_entry_reg <= ram_wentry;
    end

    sedh_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .raddr (col0[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // result queue
    assign push = s1_valid_reg;
    assign pop  = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + FIFO_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + FIFO_PTR_W'(1);
            if (push && !pop)
                fifo_cnt_reg <= fifo_cnt_reg + FIFO_CNT_W'(1);
            else if (pop && !push)
                fifo_cnt_reg <= fifo_cnt_reg - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= {s1_last_reg, ~quant_on};
    end

    assign m_axis_tvalid = (fifo_cnt_reg != '0);
    assign m_axis_tdata  = {(8 - NCH)'(0), fifo_reg[rd_ptr_reg][NCH-1:0]};
    assign m_axis_tlast  = fifo_reg[rd_ptr_reg][NCH];

    a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> !s1_wr)
        else $error("turn column write collides with a behind write");

    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |-> (fifo_cnt_reg != FIFO_CNT_W'(FIFO_DEPTH)))
        else $error("result queue overflow");

    a_sweep_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (!s1_valid_reg && !pend_valid_reg))
        else $error("store sweep overlaps pixel traffic");

    a_turn_follow: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_last_reg) |=> pend_valid_reg)
        else $error("turn column write lost");

endmodule

@@ rtl/sedh_ram.sv @@
module sedh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/sedh_chan.sv @@
module sedh_chan (
    input  sedh_pkg::pix_t pixel,
    input  sedh_pkg::err_t stored,
    input  sedh_pkg::err_t along,
    input  sedh_pkg::err_t win_behind,
    input  sedh_pkg::err_t win_below,
    input  sedh_pkg::pix_t threshold,
    input  logic           last,
    output logic           quant_on,
    output sedh_pkg::err_t along_next,
    output sedh_pkg::err_t w_behind,
    output sedh_pkg::err_t w_below,
    output sedh_pkg::err_t w_ahead
);

    import sedh_pkg::*;

    localparam logic signed [SUM_W-1:0]  FULL_V = SUM_W'(FULL_LEVEL);
    localparam logic signed [PROD_W-1:0] K_ALONG  = PROD_W'(FS_ALONG);
    localparam logic signed [PROD_W-1:0] K_BELOW  = PROD_W'(FS_BELOW);
    localparam logic signed [PROD_W-1:0] K_BEHIND = PROD_W'(FS_BEHIND);
    localparam logic signed [PROD_W-1:0] K_DIV    = PROD_W'(FS_DIV);

    logic signed [SUM_W-1:0]  inv;
    logic signed [SUM_W-1:0]  thr;
    logic signed [SUM_W-1:0]  v;
    logic signed [SUM_W-1:0]  e;
    logic signed [PROD_W-1:0] e_x;
    logic signed [PROD_W-1:0] q_along;
    logic signed [PROD_W-1:0] q_below;
    logic signed [PROD_W-1:0] q_behind;
    logic signed [PROD_W-1:0] q_ahead;

    // invert to ink level and add incoming error
    assign inv = $signed(SUM_W'(FULL_LEVEL - pixel));
    assign thr = $signed(SUM_W'(threshold));
    assign v   = inv + SUM_W'(stored) + SUM_W'(along);

    assign quant_on = (v >= thr);
    assign e        = quant_on ? (v - FULL_V) : v;
    assign e_x      = PROD_W'(e);

    // truncate each portion toward zero
    assign q_along  = (e_x * K_ALONG) / K_DIV;
    assign q_below  = (e_x * K_BELOW) / K_DIV;
    assign q_behind = (e_x * K_BEHIND) / K_DIV;
    assign q_ahead  = e_x / K_DIV;

    assign along_next = last ? '0 : sat_err(q_along);
    assign w_behind   = sat_err(PROD_W'(win_behind) + q_behind);
    assign w_below    = sat_err(PROD_W'(win_below) + q_below);
    assign w_ahead    = sat_err(q_ahead);

endmodule

@@ dv/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sedh_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 80;

    typedef struct packed {
        logic end_of_row;
        logic blue_on;
        logic green_on;
        logic red_on;
    } dots_t;

    class halftone_scoreboard;
        int    line_err[MAX_WIDTH][NCH];
        int    below_win[2][NCH];
        int    carry_err[NCH];
        int    run_pos;
        bit    odd_row;
        int    width_reg;
        int    thresh_reg;
        dots_t dots_q[$];
        int    errors;

        function new();
            clear_frame();
            width_reg  = 500;
            thresh_reg = 127;
            errors     = 0;
        endfunction

        function void clear_frame();
            foreach (line_err[i, c])
                line_err[i][c] = 0;
            foreach (below_win[i, c])
                below_win[i][c] = 0;
            foreach (carry_err[c])
                carry_err[c] = 0;
            run_pos = 0;
            odd_row = 1'b0;
        endfunction

        function void write_reg(reg_idx_t idx, int val);
            if (idx == REG_IMAGE_WIDTH)
                width_reg = val & 'h3FF;
            else
                thresh_reg = val & 'hFF;
        endfunction

        function int clamp_err(int x);
            if (x > int'(ERR_MAX))
                return int'(ERR_MAX);
            if (x < int'(ERR_MIN))
                return int'(ERR_MIN);
            return x;
        endfunction

        function void note_pixel(logic [23:0] pix, bit sof);
            int    wd;
            int    pos;
            int    col;
            int    behind;
            bit    last;
            int    v;
            int    e;
            int    w1;
            int    w2;
            bit    on;
            dots_t res;
            if (sof)
                clear_frame();
            wd = width_reg;
            if (wd < 1)
                wd = 1;
            if (wd > MAX_WIDTH)
                wd = MAX_WIDTH;
            pos = run_pos;
            if (pos > wd - 1)
                pos = wd - 1;
            col    = odd_row ? wd - 1 - pos : pos;
            behind = odd_row ? col + 1 : col - 1;
            last   = (pos == wd - 1);
            res    = '0;
            for (int ch = 0; ch < NCH; ch++)
            begin
                v  = 255 - int'(pix[8*ch +: 8]) + line_err[col][ch] + carry_err[ch];
                on = (v >= thresh_reg);
                e  = on ? v - 255 : v;
                case (ch)
                    0: res.red_on   = !on;
                    1: res.green_on = !on;
                    default: res.blue_on = !on;
                endcase
                carry_err[ch] = last ? 0 : clamp_err((e * 7) / 16);
                w1 = clamp_err(below_win[1][ch] + (e * 5) / 16);
                w2 = clamp_err(e / 16);
                if (pos > 0)
                    line_err[behind][ch] = clamp_err(below_win[0][ch] + (e * 3) / 16);
                if (last)
                begin
                    line_err[col][ch] = w1;
                    below_win[0][ch]  = 0;
                    below_win[1][ch]  = 0;
                end
                else
                begin
                    below_win[0][ch] = w1;
                    below_win[1][ch] = w2;
                end
            end
            res.end_of_row = last;
            if (last)
            begin
                run_pos = 0;
                odd_row = !odd_row;
            end
            else
                run_pos = pos + 1;
            dots_q.push_back(res);
        endfunction

        function void check_result(logic [2:0] rgb, logic row_end);
            string field[4];
            dots_t want;
            dots_t got;
            field = '{"red_on", "green_on", "blue_on", "end_of_row"};
            got   = {row_end, rgb};
            if (dots_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %b", $time, got);
                errors++;
                return;
            end
            want = dots_q.pop_front();
            for (int i = 0; i < 4; i++)
                if (want[i] !== got[i])
                begin
                    $display("%0t: %s mismatch, expected %b, actual %b",
                             $time, field[i], want[i], got[i]);
                    errors++;
                end
        endfunction

        function int pending();
            return dots_q.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    reg_idx_t             cfg_addr;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [23:0]          s_axis_tdata;
    logic                 s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [7:0]           m_axis_tdata;
    logic                 m_axis_tlast;

    halftone_scoreboard   sb = new();
    bit                   idle_on = 1'b1;
    bit                   hold_req = 1'b0;
    int                   cycle_cnt = 0;

    serpentine_error_diffusion_halftone u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    task automatic send_pixel(input logic [23:0] pix, input bit sof);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tuser  <= sof;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_pixel(pix, sof);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.write_reg(idx, int'(val));
        @(posedge clk);
    endtask

    // receiver: random backpressure plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata[2:0], m_axis_tlast);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                hold_left = $urandom_range(1, 6) - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int          sent;
        int          w;
        int          eff;
        int          len;
        int          style;
        bit          long_done;
        bit          skip_sof;
        bit          sof;
        logic [23:0] base;
        logic [23:0] pix;
        logic [2:0]  k;

        sent      = 0;
        long_done = 1'b0;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_addr      <= REG_IMAGE_WIDTH;
        cfg_wdata     <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stream with no frame start, reset settings
        send_pixel(24'h000000, 1'b0);
        send_pixel(24'hFFFFFF, 1'b0);
        send_pixel(24'h00FF80, 1'b0);
        wait_drained();

        // shrink width to end the row at the current position, lowest threshold
        write_reg(REG_IMAGE_WIDTH, 10'd4);
        write_reg(REG_THRESHOLD, 10'd0);
        send_pixel(24'h808080, 1'b0);
        send_pixel(24'hFF0000, 1'b0);
        send_pixel(24'h00FF00, 1'b0);
        send_pixel(24'h0000FF, 1'b0);
        send_pixel(24'h7F7F7F, 1'b0);
        wait_drained();

        // zero width acts as one pixel, highest threshold
        write_reg(REG_IMAGE_WIDTH, 10'd0);
        write_reg(REG_THRESHOLD, 10'd255);
        send_pixel(24'h010101, 1'b1);
        send_pixel(24'hFEFEFE, 1'b0);
        send_pixel(24'h000000, 1'b0);
        wait_drained();

        // width beyond the line store
        write_reg(REG_IMAGE_WIDTH, 10'h3FF);
        write_reg(REG_THRESHOLD, 10'd128);
        send_pixel(24'h7F807F, 1'b1);
        send_pixel(24'h807F80, 1'b0);
        send_pixel(24'hFF00FF, 1'b0);
        send_pixel(24'h00FF00, 1'b0);
        wait_drained();

        // narrow serpentine frame, error pushed off both row ends
        write_reg(REG_IMAGE_WIDTH, 10'd2);
        write_reg(REG_THRESHOLD, 10'd127);
        send_pixel(24'h000000, 1'b1);
        send_pixel(24'hFFFFFF, 1'b0);
        send_pixel(24'h000000, 1'b0);
        send_pixel(24'hFFFFFF, 1'b0);
        send_pixel(24'h404040, 1'b0);
        send_pixel(24'hC0C0C0, 1'b0);

        while (sent < 550)
        begin
            wait_drained();
            idle_on = (sent < 470) && ($urandom_range(0, 3) != 0);
            if (!long_done && sent > 150)
            begin
                hold_req  = 1'b1;
                long_done = 1'b1;
                // keep offering while the receiver holds off
                for (int i = 0; i < 8; i++)
                begin
                    send_pixel(24'($urandom), 1'b0);
                    sent++;
                end
                wait_drained();
            end
            case ($urandom_range(0, 19))
                0:       w = 0;
                1:       w = 1023;
                2:       w = 512;
                3:       w = $urandom_range(0, 1023);
                4, 5:    w = $urandom_range(13, 40);
                default: w = $urandom_range(1, 12);
            endcase
            write_reg(REG_IMAGE_WIDTH, w[CFG_W-1:0]);
            case ($urandom_range(0, 9))
                0:       write_reg(REG_THRESHOLD, 10'd0);
                1:       write_reg(REG_THRESHOLD, 10'd255);
                default: write_reg(REG_THRESHOLD, CFG_W'($urandom_range(0, 255)));
            endcase
            eff = (w < 1) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
            repeat ($urandom_range(1, 3))
            begin
                len = eff * $urandom_range(1, 5);
                if (len > 96)
                    len = $urandom_range(20, 96);
                skip_sof = ($urandom_range(0, 5) == 0);
                style    = $urandom_range(0, 3);
                base     = 24'($urandom);
                for (int i = 0; i < len && sent < 550; i++)
                begin
                    k = 3'($urandom_range(0, 7));
                    case (style)
                        0: pix = 24'($urandom);
                        1: pix = base ^ (24'($urandom) & 24'h0F0F0F);
                        2: pix = {{8{k[2]}}, {8{k[1]}}, {8{k[0]}}};
                        default: pix = base + 24'(i) * 24'h030507;
                    endcase
                    sof = (i == 0 && !skip_sof) || ($urandom_range(0, 59) == 0);
                    if (sent >= 470)
                        idle_on = 1'b0;
                    send_pixel(pix, sof);
                    sent++;
                end
            end
        end

        wait_drained();
        repeat (16) @(posedge clk);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ files.f @@
rtl/sedh_pkg.sv
rtl/sedh_ram.sv
rtl/sedh_chan.sv
rtl/serpentine_error_diffusion_halftone.sv
dv/testbench.sv
